// ===== hdl/tmcw_pkg.sv =====
// Package for the text-mode character writer.
// Holds field widths, codes, the command type passed from front to back, and defaults.
// Depends on nothing; every other file of the block but tmcw_ram imports it.
package tmcw_pkg;

  localparam int unsigned ColumnsDefault = 80;
  localparam int unsigned RowsDefault    = 25;

  localparam int unsigned FuncW    = 2;
  localparam int unsigned CharW    = 8;
  localparam int unsigned ColorW   = 4;
  localparam int unsigned ReadColW = 7;
  localparam int unsigned ReadRowW = 5;
  localparam int unsigned CellW    = 2 * ColorW + CharW;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned TabStop    = 8;

  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned RegSelLsb = 2;

  localparam logic [FuncW-1:0] FuncPut   = 2'd0;
  localparam logic [FuncW-1:0] FuncClear = 2'd1;
  localparam logic [FuncW-1:0] FuncRead  = 2'd2;

  localparam logic RegFg = 1'b0;
  localparam logic RegBg = 1'b1;

  localparam logic [CharW-1:0] ChTab   = 8'd9;
  localparam logic [CharW-1:0] ChLf    = 8'd10;
  localparam logic [CharW-1:0] ChCr    = 8'd13;
  localparam logic [CharW-1:0] ChSpace = 8'h20;

  localparam logic [ColorW-1:0] FgReset = 4'd7;
  localparam logic [ColorW-1:0] BgReset = 4'd0;
  localparam logic [CellW-1:0]  BlankCell = {{(2*ColorW){1'b0}}, ChSpace};

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CR,
    OP_LF,
    OP_TAB,
    OP_GLYPH,
    OP_CLEAR,
    OP_READ
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [CharW-1:0]    code;
    logic [ReadColW-1:0] read_col;
    logic [ReadRowW-1:0] read_row;
  } cmd_t;

  typedef struct packed {
    logic [ColorW-1:0] fg;
    logic [ColorW-1:0] bg;
  } colors_t;

endpackage

// ===== hdl/tmcw_if.sv =====
// Valid/ready channel interfaces for the text-mode character writer.
// tmcw_in_if carries requests, tmcw_out_if carries results; both use tmcw_pkg widths.
interface tmcw_in_if;
  import tmcw_pkg::*;

  logic                valid;
  logic                ready;
  logic [FuncW-1:0]    func;
  logic [CharW-1:0]    char_code;
  logic [ReadColW-1:0] read_col;
  logic [ReadRowW-1:0] read_row;

  modport source (output valid, func, char_code, read_col, read_row, input ready);
  modport sink   (input valid, func, char_code, read_col, read_row, output ready);
endinterface

interface tmcw_out_if;
  import tmcw_pkg::*;

  logic                valid;
  logic                ready;
  logic [CharW-1:0]    cell_char;
  logic [ColorW-1:0]   cell_fg;
  logic [ColorW-1:0]   cell_bg;
  logic [ReadColW-1:0] cursor_col;
  logic [ReadRowW-1:0] cursor_row;

  modport source (output valid, cell_char, cell_fg, cell_bg, cursor_col, cursor_row,
                  input ready);
  modport sink   (input valid, cell_char, cell_fg, cell_bg, cursor_col, cursor_row,
                  output ready);
endinterface

// ===== hdl/tmcw_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies; used for the screen cell store.
module tmcw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tmcw_regs.sv =====
// APB-style color register file of the text-mode character writer.
// Depends on tmcw_pkg; a clear command from the back end restores the reset colors.
module tmcw_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel_i,
  input  logic                             penable_i,
  input  logic                             pwrite_i,
  input  logic [tmcw_pkg::ApbAddrW-1:0]    paddr_i,
  input  logic [tmcw_pkg::ApbDataW-1:0]    pwdata_i,
  output logic [tmcw_pkg::ApbDataW-1:0]    prdata_o,
  input  logic                             clr_colors_i,
  output tmcw_pkg::colors_t                colors_o
);
  import tmcw_pkg::*;

  logic [ColorW-1:0] fg_q, bg_q;
  logic              wr_en;
  logic              reg_sel;

  assign wr_en   = psel_i & penable_i & pwrite_i;
  assign reg_sel = paddr_i[RegSelLsb];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= FgReset;
      bg_q <= BgReset;
    end else if (clr_colors_i) begin
      fg_q <= FgReset;
      bg_q <= BgReset;
    end else if (wr_en) begin
      if (reg_sel == RegFg) begin
        fg_q <= pwdata_i[ColorW-1:0];
      end else begin
        bg_q <= pwdata_i[ColorW-1:0];
      end
    end
  end

  assign prdata_o    = (reg_sel == RegFg) ? ApbDataW'(fg_q) : ApbDataW'(bg_q);
  assign colors_o.fg = fg_q;
  assign colors_o.bg = bg_q;

endmodule

// ===== hdl/tmcw_front.sv =====
// Front end: accepts request transfers, classifies them into commands, and queues them.
// Depends on tmcw_pkg and tmcw_in_if; the back end pops the queue.
module tmcw_front #(
  parameter int unsigned Columns = tmcw_pkg::ColumnsDefault,
  parameter int unsigned Rows    = tmcw_pkg::RowsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  tmcw_in_if.sink        in_i,
  output logic           cmd_valid_o,
  output tmcw_pkg::cmd_t cmd_o,
  input  logic           cmd_pop_i
);
  import tmcw_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  cmd_t            new_cmd;
  logic            push, pop;

  always_comb begin
    new_cmd.code     = in_i.char_code;
    new_cmd.read_col = in_i.read_col;
    new_cmd.read_row = in_i.read_row;
    unique case (in_i.func)
      FuncPut: begin
        priority if (in_i.char_code == ChCr) begin
          new_cmd.op = OP_CR;
        end else if (in_i.char_code == ChLf) begin
          new_cmd.op = OP_LF;
        end else if (in_i.char_code == ChTab) begin
          new_cmd.op = OP_TAB;
        end else begin
          new_cmd.op = OP_GLYPH;
        end
      end
      FuncClear: new_cmd.op = OP_CLEAR;
      FuncRead: begin
        if (32'(in_i.read_col) < Columns && 32'(in_i.read_row) < Rows) begin
          new_cmd.op = OP_READ;
        end else begin
          new_cmd.op = OP_NOP;
        end
      end
      default: new_cmd.op = OP_NOP;
    endcase
  end

  assign in_i.ready  = (count_q != CntW'(QueueDepth));
  assign push        = in_i.valid & in_i.ready;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_pop_i & cmd_valid_o;
  assign cmd_o       = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/tmcw_back.sv =====
// Back end: executes commands against the cursor and the screen RAM, builds results.
// Depends on tmcw_pkg and tmcw_out_if; rows are stored in a rotating order with valid bits.
module tmcw_back #(
  parameter int unsigned Columns = tmcw_pkg::ColumnsDefault,
  parameter int unsigned Rows    = tmcw_pkg::RowsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cmd_valid_i,
  input  tmcw_pkg::cmd_t                      cmd_i,
  output logic                                cmd_pop_o,
  input  tmcw_pkg::colors_t                   colors_i,
  output logic                                clr_colors_o,
  output logic                                ram_we_o,
  output logic [$clog2(Columns*Rows)-1:0]     ram_addr_o,
  output logic [tmcw_pkg::CellW-1:0]          ram_wdata_o,
  input  logic [tmcw_pkg::CellW-1:0]          ram_rdata_i,
  tmcw_out_if.source                          out_o
);
  import tmcw_pkg::*;

  localparam int unsigned ColW  = $clog2(Columns + 1);
  localparam int unsigned RowW  = $clog2(Rows);
  localparam int unsigned AddrW = $clog2(Columns * Rows);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ_ADDR,
    S_READ_DATA,
    S_PUT_ROW,
    S_PUT_CHECK,
    S_BLANK,
    S_WRITE
  } state_e;

  state_e            state_q;
  cmd_t              cmd_q;
  logic [ColW-1:0]   col_q, ptr_q, end_q;
  logic [RowW-1:0]   line_q, top_q, phys_q;
  logic [Rows-1:0]   row_valid_q;
  logic              out_valid_q, clr_q;
  logic [CharW-1:0]  res_char_q;
  logic [ColorW-1:0] res_fg_q, res_bg_q;

  logic              is_put, do_lf;
  logic [ColW:0]     tab_next;
  logic [ColW-1:0]   tab_end;

  function automatic logic [RowW-1:0] map_row(logic [RowW-1:0] row, logic [RowW-1:0] top);
    logic [RowW:0] sum;
    sum = {1'b0, row} + {1'b0, top};
    if (sum >= (RowW + 1)'(Rows)) begin
      sum = sum - (RowW + 1)'(Rows);
    end
    return sum[RowW-1:0];
  endfunction

  assign is_put = (cmd_q.op == OP_GLYPH) || (cmd_q.op == OP_TAB);
  assign do_lf  = (cmd_q.op == OP_LF) || (is_put && col_q >= ColW'(Columns));

  always_comb begin
    tab_next = ((ColW + 1)'(col_q) & ~(ColW + 1)'(TabStop - 1)) + (ColW + 1)'(TabStop);
    if (tab_next > (ColW + 1)'(Columns)) begin
      tab_end = ColW'(Columns);
    end else begin
      tab_end = tab_next[ColW-1:0];
    end
  end

  assign ram_we_o    = (state_q == S_BLANK) || (state_q == S_WRITE);
  assign ram_addr_o  = AddrW'(phys_q) * AddrW'(Columns) + AddrW'(ptr_q);
  assign ram_wdata_o = (state_q == S_BLANK) ? BlankCell :
                       {colors_i.bg, colors_i.fg,
                        (cmd_q.op == OP_TAB) ? ChSpace : cmd_q.code};

  assign cmd_pop_o    = (state_q == S_IDLE) && !out_valid_q && cmd_valid_i;
  assign clr_colors_o = clr_q;

  assign out_o.valid      = out_valid_q;
  assign out_o.cell_char  = res_char_q;
  assign out_o.cell_fg    = res_fg_q;
  assign out_o.cell_bg    = res_bg_q;
  assign out_o.cursor_col = ReadColW'(col_q);
  assign out_o.cursor_row = ReadRowW'(line_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      line_q      <= '0;
      top_q       <= '0;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
      clr_q       <= 1'b0;
    end else begin
      clr_q <= (state_q == S_DECODE) && (cmd_q.op == OP_CLEAR);
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_pop_o) begin
            cmd_q   <= cmd_i;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (do_lf) begin
            col_q <= '0;
            if (line_q == RowW'(Rows - 1)) begin
              top_q <= (top_q == RowW'(Rows - 1)) ? '0 : top_q + 1'b1;
              row_valid_q[top_q] <= 1'b0;
            end else begin
              line_q <= line_q + 1'b1;
            end
          end
          res_char_q <= '0;
          res_fg_q   <= '0;
          res_bg_q   <= '0;
          unique case (cmd_q.op)
            OP_READ: begin
              phys_q  <= map_row(RowW'(cmd_q.read_row), top_q);
              ptr_q   <= ColW'(cmd_q.read_col);
              state_q <= S_READ_ADDR;
            end
            OP_GLYPH, OP_TAB: begin
              state_q <= S_PUT_ROW;
            end
            OP_CLEAR: begin
              col_q       <= '0;
              line_q      <= '0;
              top_q       <= '0;
              row_valid_q <= '0;
              out_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end
            OP_CR: begin
              col_q       <= '0;
              out_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end
            default: begin
              out_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end
          endcase
        end
        S_READ_ADDR: begin
          if (row_valid_q[phys_q]) begin
            state_q <= S_READ_DATA;
          end else begin
            res_char_q  <= ChSpace;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_READ_DATA: begin
          res_char_q  <= ram_rdata_i[CharW-1:0];
          res_fg_q    <= ram_rdata_i[CharW +: ColorW];
          res_bg_q    <= ram_rdata_i[CharW+ColorW +: ColorW];
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        S_PUT_ROW: begin
          phys_q  <= map_row(line_q, top_q);
          ptr_q   <= col_q;
          end_q   <= (cmd_q.op == OP_TAB) ? tab_end : col_q + 1'b1;
          state_q <= S_PUT_CHECK;
        end
        S_PUT_CHECK: begin
          if (row_valid_q[phys_q]) begin
            state_q <= S_WRITE;
          end else begin
            ptr_q   <= '0;
            state_q <= S_BLANK;
          end
        end
        S_BLANK: begin
          if (ptr_q == ColW'(Columns - 1)) begin
            row_valid_q[phys_q] <= 1'b1;
            ptr_q   <= col_q;
            state_q <= S_WRITE;
          end else begin
            ptr_q <= ptr_q + 1'b1;
          end
        end
        S_WRITE: begin
          if (ptr_q + ColW'(1) == end_q) begin
            col_q       <= end_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            ptr_q <= ptr_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/text_mode_character_writer.sv =====
// Top level of the text-mode character writer: color registers, front end, back end, RAM.
// Depends on tmcw_pkg, tmcw_if, tmcw_ram, tmcw_regs, tmcw_front and tmcw_back.
//
//   Port     | Role    | Handshake            | Payload
//   in_i     | sink    | valid/ready transfer | func, char_code, read_col, read_row
//   out_o    | source  | valid/ready transfer | cell_char, cell_fg, cell_bg, cursor
//   APB      | slave   | psel/penable, pready | fg_color at 0, bg_color at 4
//
// A read from a row not written since reset, clear or scroll returns a blank cell without a RAM access;
// a put writes 1 to 8 cells (a glyph one cell, a tab up to the next tab stop).
// The first put into a row after reset, clear or scroll first blanks all Columns cells of that row.
// The back end starts one command at a time, once the previous result transfer is done.
// A two-entry command queue keeps accepting requests while a result waits.
// Reset is asynchronous; no RAM clearing pass is needed, since per-row valid bits track state.
module text_mode_character_writer #(
  parameter int unsigned Columns = tmcw_pkg::ColumnsDefault,
  parameter int unsigned Rows    = tmcw_pkg::RowsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tmcw_in_if.sink                       in_i,
  tmcw_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tmcw_pkg::ApbAddrW-1:0] paddr,
  input  logic [tmcw_pkg::ApbDataW-1:0] pwdata,
  output logic [tmcw_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);
  import tmcw_pkg::*;

  localparam int unsigned Depth = Columns * Rows;
  localparam int unsigned AddrW = $clog2(Depth);

  logic             cmd_valid, cmd_pop, clr_colors;
  cmd_t             cmd;
  colors_t          colors;
  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [CellW-1:0] ram_wdata, ram_rdata;

  assign pready = 1'b1;

  tmcw_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_o     (prdata),
    .clr_colors_i (clr_colors),
    .colors_o     (colors)
  );

  tmcw_front #(
    .Columns (Columns),
    .Rows    (Rows)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  tmcw_back #(
    .Columns (Columns),
    .Rows    (Rows)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .colors_i     (colors),
    .clr_colors_o (clr_colors),
    .ram_we_o     (ram_we),
    .ram_addr_o   (ram_addr),
    .ram_wdata_o  (ram_wdata),
    .ram_rdata_i  (ram_rdata),
    .out_o        (out_o)
  );

  tmcw_ram #(
    .Width (CellW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== tb/text_mode_character_writer_tb.sv =====
`timescale 1ns / 100ps
// Testbench for text_mode_character_writer: a directed table, then phases of random console
// traffic, each result checked against the table or an in-bench model of screen, cursor and colors.
// Depends on tmcw_pkg, tmcw_if and the block's RTL.
module text_mode_character_writer_tb;
  import tmcw_pkg::*;

  localparam int Columns = ColumnsDefault;
  localparam int Rows = RowsDefault;
  localparam int CellCount = Columns * Rows;
  localparam int TabWidth = TabStop;
  localparam int Phases = 6;
  localparam int ItemsPerPhase = 105;
  localparam int LongStall = 200;
  localparam int DrainCycles = 100;
  localparam int WatchdogLimit = 4000;

  localparam logic [FuncW-1:0] FuncUnused = 2'd3;
  localparam logic [ApbAddrW-1:0] AddrFg = ApbAddrW'(RegFg) << RegSelLsb;
  localparam logic [ApbAddrW-1:0] AddrBg = ApbAddrW'(RegBg) << RegSelLsb;

  typedef struct packed {
    logic [FuncW-1:0]    func;
    logic [CharW-1:0]    code;
    logic [ReadColW-1:0] col;
    logic [ReadRowW-1:0] row;
  } request_t;

  typedef struct packed {
    logic [CharW-1:0]    ch;
    logic [ColorW-1:0]   fg;
    logic [ColorW-1:0]   bg;
    logic [ReadColW-1:0] col;
    logic [ReadRowW-1:0] row;
  } readout_t;

  typedef struct packed {
    request_t req;
    logic     typed;
    readout_t want;
  } directed_row_t;

  localparam int DirectedCount = 21;
  localparam directed_row_t DirectedRows [DirectedCount] = '{
    '{'{FuncRead,   8'h00, 7'd0,   5'd0},  1'b1, '{8'h20, 4'd0, 4'd0, 7'd0, 5'd0}},
    '{'{FuncRead,   8'hff, 7'd79,  5'd24}, 1'b1, '{8'h20, 4'd0, 4'd0, 7'd0, 5'd0}},
    '{'{FuncRead,   8'h00, 7'd127, 5'd31}, 1'b1, '{8'h00, 4'd0, 4'd0, 7'd0, 5'd0}},
    '{'{FuncRead,   8'h00, 7'd80,  5'd0},  1'b1, '{8'h00, 4'd0, 4'd0, 7'd0, 5'd0}},
    '{'{FuncRead,   8'h00, 7'd0,   5'd25}, 1'b1, '{8'h00, 4'd0, 4'd0, 7'd0, 5'd0}},
    '{'{FuncUnused, 8'hff, 7'd127, 5'd31}, 1'b1, '{8'h00, 4'd0, 4'd0, 7'd0, 5'd0}},
    '{'{FuncPut,    8'h41, 7'h2a,  5'h15}, 1'b1, '{8'h00, 4'd0, 4'd0, 7'd1, 5'd0}},
    '{'{FuncRead,   8'h00, 7'd0,   5'd0},  1'b1, '{8'h41, 4'd7, 4'd0, 7'd1, 5'd0}},
    '{'{FuncPut,    8'h00, 7'h55,  5'h0a}, 1'b0, '0},
    '{'{FuncPut,    8'hff, 7'h7f,  5'h1f}, 1'b0, '0},
    '{'{FuncPut,    ChTab, 7'd0,   5'd0},  1'b0, '0},
    '{'{FuncPut,    ChTab, 7'd0,   5'd0},  1'b0, '0},
    '{'{FuncPut,    ChCr,  7'd0,   5'd0},  1'b1, '{8'h00, 4'd0, 4'd0, 7'd0, 5'd0}},
    '{'{FuncPut,    ChLf,  7'd0,   5'd0},  1'b1, '{8'h00, 4'd0, 4'd0, 7'd0, 5'd1}},
    '{'{FuncPut,    ChTab, 7'd0,   5'd0},  1'b0, '0},
    '{'{FuncRead,   8'h00, 7'd3,   5'd0},  1'b0, '0},
    '{'{FuncRead,   8'h00, 7'd2,   5'd0},  1'b0, '0},
    '{'{FuncPut,    8'h80, 7'd0,   5'd0},  1'b0, '0},
    '{'{FuncClear,  8'h00, 7'd0,   5'd0},  1'b1, '{8'h00, 4'd0, 4'd0, 7'd0, 5'd0}},
    '{'{FuncRead,   8'h00, 7'd0,   5'd0},  1'b1, '{8'h20, 4'd0, 4'd0, 7'd0, 5'd0}},
    '{'{FuncRead,   8'h00, 7'd8,   5'd1},  1'b1, '{8'h20, 4'd0, 4'd0, 7'd0, 5'd0}}
  };

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  tmcw_in_if  req_bus ();
  tmcw_out_if resp_bus ();

  text_mode_character_writer DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_bus),
    .out_o   (resp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [CellW-1:0]    screen_img [CellCount];
  logic [ReadColW-1:0] cursor_x;
  logic [ReadRowW-1:0] cursor_y;
  logic [ColorW-1:0]   fg_now;
  logic [ColorW-1:0]   bg_now;
  readout_t            expected_readouts [$];
  int unsigned         mismatches = 0;
  int unsigned         quiet_cycles = 0;
  bit                  stall_req = 1'b0;
  bit                  steady_run = 1'b0;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic void blank_screen();
    for (int i = 0; i < CellCount; i++) screen_img[i] = BlankCell;
    cursor_x = '0;
    cursor_y = '0;
    fg_now = FgReset;
    bg_now = BgReset;
  endfunction

  function automatic void advance_line();
    cursor_x = '0;
    if (int'(cursor_y) >= Rows - 1) begin
      cursor_y = ReadRowW'(Rows - 1);
      for (int i = 0; i < CellCount - Columns; i++) screen_img[i] = screen_img[i + Columns];
      for (int i = CellCount - Columns; i < CellCount; i++) screen_img[i] = BlankCell;
    end else begin
      cursor_y = cursor_y + 1'b1;
    end
  endfunction

  function automatic void print_byte(logic [CharW-1:0] c);
    int base;
    int stop;
    if (c == ChCr) begin
      cursor_x = '0;
    end else if (c == ChLf) begin
      advance_line();
    end else begin
      // A full row wraps before anything else lands in it.
      if (int'(cursor_x) >= Columns) advance_line();
      base = int'(cursor_y) * Columns;
      if (c == ChTab) begin
        stop = (int'(cursor_x) / TabWidth) * TabWidth + TabWidth;
        if (stop > Columns) stop = Columns;
        for (int i = int'(cursor_x); i < stop; i++) screen_img[base + i] = {bg_now, fg_now, ChSpace};
        cursor_x = ReadColW'(stop);
      end else begin
        screen_img[base + int'(cursor_x)] = {bg_now, fg_now, c};
        cursor_x = cursor_x + 1'b1;
      end
    end
  endfunction

  function automatic readout_t console_apply(request_t r);
    readout_t         o;
    logic [CellW-1:0] cell_word;
    o = '0;
    case (r.func)
      FuncPut: print_byte(r.code);
      FuncClear: blank_screen();
      FuncRead: begin
        if (int'(r.col) < Columns && int'(r.row) < Rows) begin
          cell_word = screen_img[int'(r.row) * Columns + int'(r.col)];
          o.ch = cell_word[CharW-1:0];
          o.fg = cell_word[CharW +: ColorW];
          o.bg = cell_word[CharW + ColorW +: ColorW];
        end
      end
      default: ;
    endcase
    o.col = cursor_x;
    o.row = cursor_y;
    return o;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Text runs favor glyphs and tabs so that rows fill up, wrap and hit the tab cap.
  function automatic request_t random_request(bit text_run);
    request_t r;
    int       roll;
    r.func = FuncPut;
    r.code = CharW'($urandom_range(0, 255));
    r.col = ReadColW'($urandom_range(0, 127));
    r.row = ReadRowW'($urandom_range(0, 31));
    roll = text_run ? $urandom_range(200, 299) : $urandom_range(0, 299);
    if (roll == 0) begin
      r.func = FuncClear;
    end else if (roll < 4) begin
      r.func = FuncUnused;
    end else if (roll < 44 || roll >= 280) begin
      r.func = FuncRead;
      if ($urandom_range(0, 9) != 0) r.col = ReadColW'($urandom_range(0, Columns - 1));
      roll = $urandom_range(0, 9);
      if (roll < 5) r.row = cursor_y;
      else if (roll < 9) r.row = ReadRowW'($urandom_range(0, Rows - 1));
    end else if (roll < 89) begin
      r.code = ChLf;
    end else if (roll < 104) begin
      r.code = ChCr;
    end else if (roll < 134 || roll >= 265) begin
      r.code = ChTab;
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, int want, int got);
    mismatches++;
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  task automatic send_request(request_t r, logic typed, readout_t typed_want);
    readout_t predicted;
    int       gap;
    req_bus.valid <= 1'b1;
    req_bus.func <= r.func;
    req_bus.char_code <= r.code;
    req_bus.read_col <= r.col;
    req_bus.read_row <= r.row;
    do @(posedge clk_i); while (!req_bus.ready);
    predicted = console_apply(r);
    expected_readouts.push_back(typed ? typed_want : predicted);
    gap = steady_run ? 0 : pick_gap();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    req_bus.valid <= 1'b0;
    while (expected_readouts.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_color(logic [ApbAddrW-1:0] addr, logic [ColorW-1:0] value);
    logic [ApbDataW-1:0] word;
    word = $urandom;
    word[ColorW-1:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == AddrFg) fg_now = value;
    else bg_now = value;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_results
    readout_t want;
    if (rst_ni && resp_bus.valid && resp_bus.ready) begin
      if (expected_readouts.size() == 0) begin
        report_mismatch("unexpected result", 0, 1);
      end else begin
        want = expected_readouts.pop_front();
        if (resp_bus.cell_char !== want.ch) report_mismatch("cell_char", want.ch, resp_bus.cell_char);
        if (resp_bus.cell_fg !== want.fg) report_mismatch("cell_fg", want.fg, resp_bus.cell_fg);
        if (resp_bus.cell_bg !== want.bg) report_mismatch("cell_bg", want.bg, resp_bus.cell_bg);
        if (resp_bus.cursor_col !== want.col) begin
          report_mismatch("cursor_col", want.col, resp_bus.cursor_col);
        end
        if (resp_bus.cursor_row !== want.row) begin
          report_mismatch("cursor_row", want.row, resp_bus.cursor_row);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (resp_bus.valid && resp_bus.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WatchdogLimit);
    $display("text_mode_character_writer test failed");
    $finish;
  end

  // The long hold-off fills the command queue so that the input side stalls.
  initial begin
    resp_bus.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (stall_req) begin
        stall_req = 1'b0;
        resp_bus.ready <= 1'b0;
        repeat (LongStall) @(posedge clk_i);
      end else if (!steady_run && $urandom_range(0, 3) == 0) begin
        resp_bus.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk_i);
      end else begin
        resp_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned run_left;
    request_t    r;
    req_bus.valid <= 1'b0;
    req_bus.func <= '0;
    req_bus.char_code <= '0;
    req_bus.read_col <= '0;
    req_bus.read_row <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    blank_screen();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int n = 0; n < DirectedCount; n++) begin
      send_request(DirectedRows[n].req, DirectedRows[n].typed, DirectedRows[n].want);
    end

    run_left = 0;
    for (int phase = 0; phase < Phases; phase++) begin
      drain_results();
      case (phase)
        0: begin
          write_color(AddrFg, 4'h0);
          write_color(AddrBg, 4'hf);
        end
        1: begin
          write_color(AddrFg, 4'hf);
          write_color(AddrBg, 4'h0);
        end
        2: begin
          write_color(AddrFg, 4'hf);
          write_color(AddrBg, 4'hf);
        end
        3: begin
          write_color(AddrBg, 4'h0);
          write_color(AddrFg, 4'h0);
        end
        default: begin
          write_color(AddrFg, ColorW'($urandom_range(0, 15)));
          write_color(AddrBg, ColorW'($urandom_range(0, 15)));
        end
      endcase
      steady_run = (phase == 3);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (phase == 2 && n == 20) stall_req = 1'b1;
        if (run_left == 0 && $urandom_range(0, 59) == 0) run_left = $urandom_range(60, 100);
        r = random_request(run_left != 0);
        if (run_left != 0) run_left--;
        send_request(r, 1'b0, '0);
      end
    end
    steady_run = 1'b0;

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_readouts.size() != 0) begin
      report_mismatch("results left over", 0, expected_readouts.size());
    end
    if (mismatches == 0) begin
      $display("text_mode_character_writer test passed");
    end else begin
      $display("text_mode_character_writer test failed");
    end
    $finish;
  end

endmodule
